/* hw/rtl/anfpe_pkg.sv */
// shared types and constants of the algebraic normal form evaluator
// no dependencies; imported by the cell and the top level
package anfpe_pkg;

    // sizes of the variable space and of the coefficient store
    localparam int MAX_VARS    = 10;
    localparam int WORD_BITS   = 32;
    localparam int WORD_AW     = 5;
    localparam int POINT_W     = MAX_VARS;
    localparam int STORE_AW    = MAX_VARS - WORD_AW;
    localparam int STORE_WORDS = 1 << STORE_AW;
    localparam int NV_W        = 4;
    localparam int WIDX_W      = 5;

    localparam logic [NV_W-1:0] MAX_VARS_V = NV_W'(MAX_VARS);

    // request codes
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_EVAL = 1'b1;

    // evaluation token handed from cell to cell
    typedef struct packed {
        logic                 err;
        logic                 acc;
        logic [STORE_AW-1:0]  pt_hi;
        logic [WORD_BITS-1:0] lo_mask;
    } tok_t;

endpackage

/* hw/rtl/anfpe_cell.sv */
// one cell of the evaluation chain: holds one coefficient word and one token stage
// depends on anfpe_pkg
module anfpe_cell
    import anfpe_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  logic                 wr_en,
    input  logic [WORD_BITS-1:0] wr_data,
    input  logic [STORE_AW-1:0]  cell_idx,
    input  logic                 vld_in,
    input  tok_t                 tok_in,
    output logic                 vld_out,
    output tok_t                 tok_out
);

    logic [WORD_BITS-1:0] word_reg;
    logic                 vld_reg;
    tok_t                 tok_reg;
    tok_t                 tok_next;
    logic                 hit;

    // fold this word into the running parity when its monomials lie under the point
    always_comb
    begin
        hit          = !tok_in.err && ((cell_idx & ~tok_in.pt_hi) == '0);
        tok_next     = tok_in;
        tok_next.acc = tok_in.acc ^ (hit & (^(word_reg & tok_in.lo_mask)));
    end

    // coefficient word, cleared to constant false at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg <= '0;
        end
        else if (wr_en)
        begin
            word_reg <= wr_data;
        end
    end

    // token valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg <= vld_in;
        end
    end

    // token payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tok_reg <= tok_next;
        end
    end

    assign vld_out = vld_reg;
    assign tok_out = tok_reg;

endmodule

/* hw/rtl/anf_polynomial_evaluator_top.sv */
// Algebraic normal form (XOR of ANDs) polynomial evaluator.
// Input channel (in_valid / in_stall) carries requests: func selects a load of one
// 32-bit coefficient word (word_index, word_data) or an evaluation at point.
// A load gives no result; a word_index beyond the store is ignored.
// An evaluation gives one result on the output channel (out_valid / out_stall):
// value, or range_error with value 0 when point is not below 2^num_vars.
// The user writes num_vars (cfg_wr_en / cfg_wr_data) only while the block is idle;
// the block does not enforce this; values above the maximum are treated as the maximum.
// An evaluation token walks the row of coefficient cells, one word per cycle while the
// chain is not held; the result is registered as the token leaves the last cell, and a
// new request is taken in the cycle the token leaves the last cell.
// Loads are taken back to back while no evaluation is in the chain.
// Reset clears the coefficient store (constant false), num_vars and all valid flags.
// A stalled result stays in the output register; a finished token waits in the last
// cell and the chain holds until the register frees, and in_stall stays high meanwhile.
// depends on anfpe_pkg and anfpe_cell
module anf_polynomial_evaluator_top
    import anfpe_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [NV_W-1:0]      cfg_wr_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 func,
    input  logic [WIDX_W-1:0]    word_index,
    input  logic [WORD_BITS-1:0] word_data,
    input  logic [POINT_W-1:0]   point,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 value,
    output logic                 range_error
);

    logic [NV_W-1:0]      num_vars_reg;
    logic                 busy_reg;
    logic                 busy_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 value_reg;
    logic                 err_reg;
    logic                 adv;
    logic                 last_leave;
    logic                 in_acc;
    logic                 eval_acc;
    logic                 load_acc;
    logic [NV_W-1:0]      n_eff;
    tok_t                 tok_first;
    logic                 vld_chain [STORE_WORDS+1];
    tok_t                 tok_chain [STORE_WORDS+1];
    logic [STORE_WORDS-1:0] wr_sel;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_vars_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            num_vars_reg <= cfg_wr_data;
        end
    end

    // handshake of the input side
    assign last_leave = vld_chain[STORE_WORDS] && adv;
    assign in_stall   = busy_reg && !last_leave;
    assign in_acc     = in_valid && !in_stall;
    assign eval_acc   = in_acc && (func == FUNC_EVAL);
    assign load_acc   = in_acc && (func == FUNC_LOAD);

    // chain holds while a finished token cannot enter the output register
    assign adv = !(vld_chain[STORE_WORDS] && out_valid_reg && out_stall);

    // token built from the request: range check and low subset mask
    always_comb
    begin
        n_eff             = (num_vars_reg > MAX_VARS_V) ? MAX_VARS_V : num_vars_reg;
        tok_first.err     = (point >> n_eff) != '0;
        tok_first.acc     = 1'b0;
        tok_first.pt_hi   = point[POINT_W-1:WORD_AW];
        for (int b = 0; b < WORD_BITS; b++)
        begin
            tok_first.lo_mask[b] = ((WORD_AW'(b) & ~point[WORD_AW-1:0]) == '0);
        end
    end

    assign vld_chain[0] = eval_acc;
    assign tok_chain[0] = tok_first;

    // row of coefficient cells
    for (genvar k = 0; k < STORE_WORDS; k++)
    begin : g_cell
        assign wr_sel[k] = load_acc && (int'(word_index) == k);

        anfpe_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .adv      (adv),
            .wr_en    (wr_sel[k]),
            .wr_data  (word_data),
            .cell_idx (STORE_AW'(k)),
            .vld_in   (vld_chain[k]),
            .tok_in   (tok_chain[k]),
            .vld_out  (vld_chain[k+1]),
            .tok_out  (tok_chain[k+1])
        );
    end

    // busy while an evaluation is in the chain
    always_comb
    begin
        busy_next = busy_reg;
        if (last_leave)
        begin
            busy_next = 1'b0;
        end
        if (eval_acc)
        begin
            busy_next = 1'b1;
        end
    end

    // output register valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (last_leave)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (last_leave)
        begin
            value_reg <= tok_chain[STORE_WORDS].acc && !tok_chain[STORE_WORDS].err;
            err_reg   <= tok_chain[STORE_WORDS].err;
        end
    end

    assign out_valid   = out_valid_reg;
    assign value       = value_reg;
    assign range_error = err_reg;

endmodule

/* hw/rtl/anfpe_checker.sv */
// port-level checks of the algebraic normal form evaluator, bound to the top level
// depends on anfpe_pkg and anf_polynomial_evaluator_top
module anfpe_checker
    import anfpe_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_stall,
    input logic func,
    input logic out_valid,
    input logic out_stall,
    input logic value,
    input logic range_error
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(value) && $stable(range_error))
        else $error("stalled result changed");

    // an out-of-range point never reports a set value
    a_err_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && range_error |-> !value)
        else $error("range error with value set");

    // an evaluation occupies the chain, so the next request waits
    a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (func == FUNC_EVAL) |=> in_stall)
        else $error("request taken while chain busy");

    // a result cannot appear right after reset
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result right after reset");

endmodule

bind anf_polynomial_evaluator_top anfpe_checker u_anfpe_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .func        (func),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .value       (value),
    .range_error (range_error)
);
